// ----- design/worker_pick_least_loaded_or_hash_assert.svh -----
// Assertion macros used by the back end of the worker selector.
`ifndef WORKER_PICK_LEAST_LOADED_OR_HASH_ASSERT_SVH
`define WORKER_PICK_LEAST_LOADED_OR_HASH_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define WPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define WPL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPL_ASSERT(lbl, prop, msg)
`define WPL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- design/wpl_pkg.sv -----
// Types, constants and helpers shared by the worker selection modules.
`timescale 1ns / 1ps
package wpl_pkg;

  localparam int MAX_WORKERS = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int KEY_W       = 64;
  localparam int LOAD_W      = 16;
  localparam int HALF_W      = 32;

  localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int               MIX_SHIFT = 33;

  // Stream layout
  localparam int S_TDATA_W  = 200;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 8;
  localparam int M_TUSER_W  = 2;
  localparam int PREF_BIT   = 64;
  localparam int CUR_LO     = 65;
  localparam int LOADS_LO   = 69;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFER_EN    = 2'd1;
  localparam logic [CNT_W-1:0]     WORKER_COUNT_RST = 4'd8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_HASH = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    BY_OWN  = 2'd0,
    BY_LOAD = 2'd1,
    BY_HASH = 2'd2
  } chosen_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    chosen_t                            kind;
    logic [KEY_W-1:0]                   key;
    logic [IDX_W-1:0]                   worker;
    logic [MAX_WORKERS-1:0][LOAD_W-1:0] loads;
  } job_t;

  // Clamp the worker count register to 1..MAX_WORKERS.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] wc);
    logic [CNT_W-1:0] n;
    n = wc;
    if (wc == '0) n = CNT_W'(1);
    else if (wc > CNT_W'(MAX_WORKERS)) n = CNT_W'(MAX_WORKERS);
    return n;
  endfunction

endpackage

// ----- design/worker_pick_least_loaded_or_hash.sv -----
// Top level of the worker selector: registers, front end, queue and back end.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  s_*      | s_tvalid / s_tready  | tuser: operation; tdata: key, own_request,
//           |                      |   current_worker, load_0..load_7
//  m_*      | m_tvalid / m_tready  | tuser: chosen_by; tdata: worker_index
//  cfg_*    | cfg_valid / cfg_ready| cfg_index selects register, cfg_data
//
// Work per request, set by the back end sequencer: own worker goes straight
// to the result, load scan compares one worker load per cycle over the active
// workers, key hash runs two 64-bit multiplies as three 32x32 partial products
// each, then a 16-step modulo taking four key bits per cycle.
// Reset (rst, synchronous) empties the queue and result register, zeroes the
// scan start, and loads worker_count = 8 with the own-worker preference off.
// The front end keeps taking requests while the two-entry queue has room, and
// the back end holds a finished result until m_tready takes it.
// Configuration writes are always accepted.
`timescale 1ns / 1ps
module worker_pick_least_loaded_or_hash
  import wpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [63:0] key, [64] own_request, [68:65] current_worker,
  // [84:69] load_0 ... [196:181] load_7, [199:197] zero
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // [0] operation
  input  logic [S_TUSER_W-1:0]  s_tuser,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [2:0] worker_index, [7:3] zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  // [1:0] chosen_by
  output logic [M_TUSER_W-1:0]  m_tuser,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT_W-1:0] worker_count;
  logic             prefer_en;
  logic [CNT_W-1:0] n_eff;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  // Registers take a write in any cycle; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= WORKER_COUNT_RST;
      prefer_en    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WORKER_COUNT: worker_count <= cfg_data;
        CFG_PREFER_EN:    prefer_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Out-of-range counts act as the nearest legal count.
  assign n_eff = eff_count(worker_count);

  wpl_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .n_eff     (n_eff),
    .prefer_en (prefer_en),
    .q_full    (q_full),
    .push      (q_push),
    .job       (push_job)
  );

  wpl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  wpl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .n_eff    (n_eff),
    .q_empty  (q_empty),
    .head     (head_job),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- design/wpl_front.sv -----
// Front end: accepts requests and classifies them into queued jobs.
`timescale 1ns / 1ps
module wpl_front
  import wpl_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic [CNT_W-1:0]     n_eff,
  input  logic                 prefer_en,
  input  logic                 q_full,
  output logic                 push,
  output job_t                 job
);

  logic             pref;
  logic [CNT_W-1:0] cur;

  assign pref     = s_tdata[PREF_BIT];
  assign cur      = s_tdata[CUR_LO +: CNT_W];
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    job.key    = s_tdata[KEY_W-1:0];
    job.worker = cur[IDX_W-1:0];
    for (int i = 0; i < MAX_WORKERS; i++) begin
      job.loads[i] = s_tdata[LOADS_LO + i*LOAD_W +: LOAD_W];
    end
    // Own worker only when asked, allowed and in range
    if (s_tuser[0] == OP_HASH) job.kind = BY_HASH;
    else if (pref && prefer_en && (cur < n_eff)) job.kind = BY_OWN;
    else job.kind = BY_LOAD;
  end

endmodule

// ----- design/wpl_queue.sv -----
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
module wpl_queue
  import wpl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ----- design/wpl_back.sv -----
// Back end: hash with modulo, load scan, and the result register.
`timescale 1ns / 1ps
module wpl_back
  import wpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_W-1:0]     n_eff,
  input  logic                 q_empty,
  input  job_t                 head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser
);

  `include "worker_pick_least_loaded_or_hash_assert.svh"

  back_state_t state, state_next;

  logic [KEY_W-1:0]  x;
  logic [KEY_W-1:0]  acc;
  logic              mul_b;
  logic [1:0]        sub;
  logic [CNT_W-1:0]  mcnt;
  logic [IDX_W-1:0]  rem;
  logic [LOAD_W-1:0] loads [MAX_WORKERS];
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  best;
  logic [LOAD_W-1:0] minl;
  logic [IDX_W-1:0]  scnt;
  logic [IDX_W-1:0]  scan_start;
  logic [IDX_W-1:0]  res_idx;
  chosen_t           res_by;
  logic              out_valid;
  logic [IDX_W-1:0]  out_idx;
  chosen_t           out_by;

  // Multiplier step: one 32x32 partial product a cycle
  logic [KEY_W-1:0]  mul_c;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_k;
  logic [KEY_W-1:0]  prod;
  logic [KEY_W-1:0]  mix_sum;

  // Modulo step: four bits a cycle
  logic [IDX_W-1:0]  rem_new;

  // Scan step
  logic [LOAD_W-1:0] cur_load;
  logic              take;
  logic [IDX_W-1:0]  best_new;
  logic [IDX_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  best_inc;
  logic              scan_last;
  logic              out_load;

  assign mul_c   = mul_b ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a   = (sub == 2'd2) ? x[KEY_W-1:HALF_W] : x[HALF_W-1:0];
  assign mul_k   = (sub == 2'd1) ? mul_c[KEY_W-1:HALF_W] : mul_c[HALF_W-1:0];
  assign prod    = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_k};
  assign mix_sum = acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

  always_comb begin
    logic [CNT_W-1:0] t;
    logic [IDX_W-1:0] r;
    r = rem;
    for (int k = 0; k < 4; k++) begin
      t = {r, x[KEY_W-1-k]};
      if (t >= n_eff) t = t - n_eff;
      r = t[IDX_W-1:0];
    end
    rem_new = r;
  end

  assign cur_load  = loads[idx];
  assign take      = (scnt == '0) || (cur_load < minl);
  assign best_new  = take ? idx : best;
  assign idx_inc   = ({1'b0, idx} + CNT_W'(1) == n_eff) ? '0 : idx + IDX_W'(1);
  assign best_inc  = ({1'b0, best_new} + CNT_W'(1) == n_eff) ? '0 : best_new + IDX_W'(1);
  assign scan_last = ({1'b0, scnt} == n_eff - CNT_W'(1));
  assign out_load  = (state == ST_DONE) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.kind)
            BY_HASH: state_next = ST_MUL;
            BY_OWN:  state_next = ST_DONE;
            default: state_next = ST_SCAN;
          endcase
        end
      end
      ST_MUL: begin
        if (sub == 2'd2 && mul_b) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (mcnt == '1) state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          x       <= head.key ^ (head.key >> MIX_SHIFT);
          sub     <= '0;
          mul_b   <= 1'b0;
          res_idx <= head.worker;
          res_by  <= head.kind;
          scnt    <= '0;
          for (int i = 0; i < MAX_WORKERS; i++) loads[i] <= head.loads[i];
          idx     <= ({1'b0, scan_start} >= n_eff) ? '0 : scan_start;
        end
      end
      ST_MUL: begin
        if (sub == 2'd0) begin
          acc <= prod;
          sub <= 2'd1;
        end else if (sub == 2'd1) begin
          acc <= mix_sum;
          sub <= 2'd2;
        end else begin
          x     <= mix_sum ^ (mix_sum >> MIX_SHIFT);
          sub   <= 2'd0;
          mul_b <= 1'b1;
          mcnt  <= '0;
          rem   <= '0;
        end
      end
      ST_MOD: begin
        x    <= x << 4;
        rem  <= rem_new;
        mcnt <= mcnt + CNT_W'(1);
        if (mcnt == '1) res_idx <= rem_new;
      end
      ST_SCAN: begin
        best <= best_new;
        if (take) minl <= cur_load;
        idx  <= idx_inc;
        scnt <= scnt + IDX_W'(1);
        if (scan_last) res_idx <= best_new;
      end
      default: ;
    endcase
  end

  // Rotating start, moved only by a load scan
  always_ff @(posedge clk) begin
    if (rst) scan_start <= '0;
    else if (state == ST_SCAN && scan_last) scan_start <= best_inc;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx <= res_idx;
      out_by  <= res_by;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W-IDX_W){1'b0}}, out_idx};
  assign m_tuser  = out_by;

  `WPL_ASSERT(a_res_in_range, (state == ST_DONE) |-> ({1'b0, res_idx} < n_eff), "result beyond worker count")
  `WPL_ASSERT(a_scan_in_range, (state == ST_SCAN) |-> ({1'b0, idx} < n_eff), "scan index beyond worker count")
  `WPL_ASSERT(a_valid_from_done, $rose(out_valid) |-> $past(state == ST_DONE), "result raised outside done")
  `WPL_ASSERT_RST(a_reset_clears, rst |=> (state == ST_IDLE && !out_valid), "reset left back end busy")

endmodule
